[rtl/windowed_rms_level_meter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the windowed RMS level meter
// Concurrent checks clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RMS_LEVEL_METER_MACROS_SVH
`define WINDOWED_RMS_LEVEL_METER_MACROS_SVH

// same-cycle implication
`define WRLM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WRLM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/wrlm_pkg.sv]
// ----------------------------------------------------------------------------
// wrlm_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wrlm_pkg;

   localparam int SAMPLE_BITS        = 16;
   localparam int MAX_WINDOW_SAMPLES = 65536;

   localparam int IN_W    = 16;               // sample field width
   localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
   localparam int SUM_W   = 48;
   localparam int CNT_W   = 17;
   localparam int RMS_W   = 16;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int SREM_W  = ROOT_W + 1;
   localparam int TDATA_W = 40;               // rms + window_samples, byte padded
   localparam int TUSER_W = 2;

   localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
   localparam int COUNT_LIMIT   = (MAX_WINDOW_SAMPLES < CNT_FIELD_MAX) ?
                                  MAX_WINDOW_SAMPLES : CNT_FIELD_MAX;
   localparam int UP_SHIFT      = (SAMPLE_BITS < 16) ? 2 * (16 - SAMPLE_BITS) : 0;
   localparam int DOWN_SHIFT    = (SAMPLE_BITS > 16) ? (SAMPLE_BITS - 16) : 0;

   localparam int DIV_STEPS  = SUM_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
   localparam logic [RMS_W-1:0] RMS_FULL = RMS_W'(32768);

   typedef struct packed {
      logic take;       // input item transferred
      logic load;       // latch window totals, clear accumulators
      logic div_step;
      logic sq_init;
      logic sq_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;   // output register can take a result this cycle
   } status_type;

endpackage

[rtl/wrlm_ctrl.sv]
// ----------------------------------------------------------------------------
// wrlm_ctrl
// Sequencer: accumulate, then divide and square root bit by bit.
// ----------------------------------------------------------------------------
module wrlm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  wrlm_pkg::status_type status,
   output wrlm_pkg::cmd_type    cmd
);
   import wrlm_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FIN    = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_SQINIT = 3'd4;
   localparam logic [2:0] ST_SQRT   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // last square lands in the sum this cycle
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_SQINIT;
            end
         end
         ST_SQINIT: begin
            cmd.sq_init = 1'b1;
            step_in     = '0;
            state_in    = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sq_step = 1'b1;
            step_in     = step_ff + 1'b1;
            if (step_ff == SQRT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[rtl/wrlm_datapath.sv]
// ----------------------------------------------------------------------------
// wrlm_datapath
// Square/accumulate, restoring divider, bit-pair square root, output register.
// ----------------------------------------------------------------------------
module wrlm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  wrlm_pkg::cmd_type                   cmd,
   output wrlm_pkg::status_type                status,
   input  logic [wrlm_pkg::IN_W-1:0]           req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wrlm_pkg::TDATA_W-1:0]        rsp_tdata,
   output logic [wrlm_pkg::TUSER_W-1:0]        rsp_tuser
);
   import wrlm_pkg::*;

   // accumulator stage
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic             sq_pend_ff, sq_pend_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             sat_ff, sat_in;

   // divider
   logic [SUM_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] win_cnt_ff, win_cnt_in;
   logic             win_sat_ff, win_sat_in;

   // square root
   logic [SUM_W-1:0]  rad_ff, rad_in;
   logic [SREM_W-1:0] srem_ff, srem_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [RMS_W-1:0]   out_rms_ff, out_rms_in;
   logic [CNT_W-1:0]   out_cnt_ff, out_cnt_in;
   logic               out_empty_ff, out_empty_in;
   logic               out_sat_ff, out_sat_in;

   logic signed [SAMPLE_BITS-1:0]   smp;
   logic signed [2*SAMPLE_BITS-1:0] prod;
   logic [CNT_W:0]    rem_t;
   logic              q_bit;
   logic [SREM_W+1:0] srem_t;
   logic [SREM_W+1:0] trial;
   logic              r_bit;
   logic [ROOT_W-1:0] root_sh;

   assign smp  = $signed(req_tdata[SAMPLE_BITS-1:0]);
   assign prod = smp * smp;

   assign rem_t = {rem_ff, dvd_ff[SUM_W-1]};
   assign q_bit = (rem_t >= {1'b0, dvs_ff});

   assign srem_t  = {srem_ff, rad_ff[SUM_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign r_bit   = (srem_t >= trial);
   assign root_sh = root_ff >> DOWN_SHIFT;

   always_comb begin
      sq_in      = sq_ff;
      sq_pend_in = 1'b0;
      count_in   = count_ff;
      sum_in     = sum_ff;
      sat_in     = sat_ff;

      // squares are added in the cycle after the transfer
      if (sq_pend_ff) begin
         if (SUM_W'(sq_ff) > (SUM_MAX - sum_ff)) begin
            sum_in = SUM_MAX;
            sat_in = 1'b1;
         end else begin
            sum_in = sum_ff + SUM_W'(sq_ff);
         end
      end

      if (cmd.take && req_tuser) begin
         if (count_ff >= CNT_W'(COUNT_LIMIT)) begin
            sat_in = 1'b1;
         end else begin
            count_in   = count_ff + 1'b1;
            sq_in      = prod[SQ_W-1:0];
            sq_pend_in = 1'b1;
         end
      end

      if (cmd.load) begin
         sum_in   = '0;
         count_in = '0;
         sat_in   = 1'b0;
      end
   end

   always_comb begin
      dvd_in     = dvd_ff;
      dvs_in     = dvs_ff;
      rem_in     = rem_ff;
      win_cnt_in = win_cnt_ff;
      win_sat_in = win_sat_ff;
      if (cmd.load) begin
         dvd_in     = sum_ff;
         dvs_in     = count_ff;
         rem_in     = '0;
         win_cnt_in = count_ff;
         win_sat_in = sat_ff;
      end else if (cmd.div_step) begin
         rem_in = q_bit ? CNT_W'(rem_t - {1'b0, dvs_ff}) : rem_t[CNT_W-1:0];
         dvd_in = {dvd_ff[SUM_W-2:0], q_bit};
      end
   end

   always_comb begin
      rad_in  = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      if (cmd.sq_init) begin
         rad_in  = dvd_ff << UP_SHIFT;
         srem_in = '0;
         root_in = '0;
      end else if (cmd.sq_step) begin
         rad_in  = {rad_ff[SUM_W-3:0], 2'b00};
         srem_in = r_bit ? SREM_W'(srem_t - trial) : srem_t[SREM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], r_bit};
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_rms_in   = out_rms_ff;
      out_cnt_in   = out_cnt_ff;
      out_empty_in = out_empty_ff;
      out_sat_in   = out_sat_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_cnt_in   = win_cnt_ff;
         out_empty_in = (win_cnt_ff == '0);
         out_sat_in   = win_sat_ff;
         if (win_cnt_ff == '0) begin
            out_rms_in = '0;
         end else if (root_sh > ROOT_W'(RMS_FULL)) begin
            out_rms_in = RMS_FULL;
         end else begin
            out_rms_in = root_sh[RMS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_pend_ff   <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sq_pend_ff   <= sq_pend_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sat_ff       <= sat_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff        <= sq_in;
      dvd_ff       <= dvd_in;
      dvs_ff       <= dvs_in;
      rem_ff       <= rem_in;
      win_cnt_ff   <= win_cnt_in;
      win_sat_ff   <= win_sat_in;
      rad_ff       <= rad_in;
      srem_ff      <= srem_in;
      root_ff      <= root_in;
      out_rms_ff   <= out_rms_in;
      out_cnt_ff   <= out_cnt_in;
      out_empty_ff <= out_empty_in;
      out_sat_ff   <= out_sat_in;
   end

   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - RMS_W - CNT_W){1'b0}}, out_cnt_ff, out_rms_ff};
   assign rsp_tuser  = {out_sat_ff, out_empty_ff};

endmodule

[rtl/windowed_rms_level_meter.sv]
// ----------------------------------------------------------------------------
// windowed_rms_level_meter
// RMS level of interleaved PCM samples over windows closed by tlast.
// ----------------------------------------------------------------------------
// Input stream req_*: tdata = sample, tuser = has_sample, tlast = window_end.
// Items inside a window transfer at one per cycle; each valid sample is
// squared and added to a 48-bit sum, with a sample count beside it.
// An item with tlast closes the window after its own sample. The block then
// stops taking input while it settles the last square, latches the totals,
// runs the bit-serial restoring divider (sum / count), starts and runs the
// bit-pair square root and moves the result into the output register.
// rsp_tvalid rises and input opens again in the same cycle.
// Output stream rsp_*: one transfer per closed window, rms and window_samples
// in tdata, empty_window and saturated flags in tuser. An empty window gives
// rms 0 with empty_window set. Sum and count saturate and raise saturated.
// A stalled receiver holds the result in the output register; the next
// window still accumulates, and only its closing result waits for the
// register to free up, with input held off until then.
// Reset (synchronous) clears the accumulators, the sequencer and the output.
// ----------------------------------------------------------------------------
`include "windowed_rms_level_meter_macros.svh"

module windowed_rms_level_meter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wrlm_pkg::IN_W-1:0]           req_tdata,   // [15:0] sample
   input  logic                                req_tuser,   // [0] has_sample
   input  logic                                req_tlast,   // window_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wrlm_pkg::TDATA_W-1:0]        rsp_tdata,   // [15:0] rms, [32:16] window_samples
   output logic [wrlm_pkg::TUSER_W-1:0]        rsp_tuser    // [0] empty_window, [1] saturated
);
   import wrlm_pkg::*;

   cmd_type    cmd;
   status_type status;

   wrlm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wrlm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `WRLM_ASSERT_IMPL(a_empty_zero, rsp_tvalid && rsp_tuser[0],
      (rsp_tdata[15:0] == '0) && (rsp_tdata[32:16] == '0),
      "empty window result must carry zero rms and count")
   `WRLM_ASSERT_IMPL(a_count_nonempty, rsp_tvalid && !rsp_tuser[0],
      rsp_tdata[32:16] != '0,
      "non-empty window result must carry a count")
   `WRLM_ASSERT_IMPL(a_rms_range, rsp_tvalid, rsp_tdata[15:0] <= RMS_FULL,
      "rms above full scale")
   `WRLM_ASSERT_NEXT(a_close_busy, req_tvalid && req_tready && req_tlast, !req_tready,
      "input must stall after a window closes")

endmodule
